// File: hw/rtl/abp_pkg.sv
package abp_pkg;

  // Channel and pixel geometry
  localparam int unsigned PixW   = 32;
  localparam int unsigned ChanW  = 8;
  localparam int unsigned NumCol = 3;
  localparam int unsigned ProdW  = 2 * ChanW;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ChanW-1:0] ChanMax = {ChanW{1'b1}};

  // Operation codes
  typedef enum logic [2:0] {
    MODE_COPY    = 3'd0,
    MODE_INV_SRC = 3'd1,
    MODE_INV_DST = 3'd2,
    MODE_SRC_A   = 3'd3,
    MODE_DST_A   = 3'd4,
    MODE_ADD     = 3'd5,
    MODE_SUB     = 3'd6,
    MODE_CONST_A = 3'd7
  } blend_mode_e;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_BLEND_MODE    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_CONST_ALPHA   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SOURCE_SELECT = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_FILL_COLOR    = 2'd3;

  localparam logic [ChanW-1:0] ConstAlphaRst = 8'hFF;

  // Programmed settings
  typedef struct packed {
    blend_mode_e      mode;
    logic [ChanW-1:0] const_alpha;
    logic             source_select;
    logic [PixW-1:0]  fill_color;
  } cfg_t;

  // Operands after source and alpha selection
  typedef struct packed {
    blend_mode_e      mode;
    logic [PixW-1:0]  src;
    logic [PixW-1:0]  dst;
    logic [ChanW-1:0] alpha;
  } op_t;

  // Products and direct result
  typedef struct packed {
    logic                          is_blend;
    logic [NumCol-1:0][ProdW-1:0]  prod_s;
    logic [NumCol-1:0][ProdW-1:0]  prod_d;
    logic [PixW-1:0]               direct;
  } mix_t;

  function automatic logic [ChanW-1:0] add_sat(input logic [ChanW-1:0] s,
                                               input logic [ChanW-1:0] d);
    logic [ChanW:0] sum;
    sum = {1'b0, s} + {1'b0, d};
    return sum[ChanW] ? ChanMax : sum[ChanW-1:0];
  endfunction

  function automatic logic [ChanW-1:0] sub_sat(input logic [ChanW-1:0] s,
                                               input logic [ChanW-1:0] d);
    return (d > s) ? (d - s) : '0;
  endfunction

endpackage

// File: hw/rtl/abp_cfg_regs.sv
module abp_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [abp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [abp_pkg::PixW-1:0]      cfg_data_i,
  output abp_pkg::cfg_t                 cfg_o
);
  import abp_pkg::*;

  cfg_t cfg_q;

  // Always take a write
  assign cfg_ready_o = 1'b1;

  // Update the addressed register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode          <= MODE_COPY;
      cfg_q.const_alpha   <= ConstAlphaRst;
      cfg_q.source_select <= 1'b0;
      cfg_q.fill_color    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BLEND_MODE:    cfg_q.mode          <= blend_mode_e'(cfg_data_i[2:0]);
        REG_CONST_ALPHA:   cfg_q.const_alpha   <= cfg_data_i[ChanW-1:0];
        REG_SOURCE_SELECT: cfg_q.source_select <= cfg_data_i[0];
        REG_FILL_COLOR:    cfg_q.fill_color    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/abp_operand_stage.sv
module abp_operand_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [abp_pkg::PixW-1:0]  src_i,
  input  logic [abp_pkg::PixW-1:0]  dst_i,
  input  abp_pkg::cfg_t             cfg_i,
  output logic                      valid_o,
  output abp_pkg::op_t              op_o
);
  import abp_pkg::*;

  logic valid_q;
  op_t  op_d, op_q;

  // Pick the source and the blend alpha
  always_comb begin
    op_d.mode = cfg_i.mode;
    op_d.src  = cfg_i.source_select ? cfg_i.fill_color : src_i;
    op_d.dst  = dst_i;
    case (cfg_i.mode)
      MODE_SRC_A: op_d.alpha = op_d.src[PixW-1 -: ChanW];
      MODE_DST_A: op_d.alpha = dst_i[PixW-1 -: ChanW];
      default:    op_d.alpha = cfg_i.const_alpha;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      op_q <= op_d;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;

endmodule

// File: hw/rtl/abp_mix_stage.sv
module abp_mix_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  abp_pkg::op_t  op_i,
  output logic          valid_o,
  output abp_pkg::mix_t mix_o
);
  import abp_pkg::*;

  logic             valid_q;
  mix_t             mix_d, mix_q;
  logic [ChanW-1:0] inv_alpha;
  logic [ChanW-1:0] s_ch, d_ch;

  assign inv_alpha = ChanMax - op_i.alpha;

  // Form the channel products and the non-blend result
  always_comb begin
    mix_d.is_blend = (op_i.mode == MODE_SRC_A) || (op_i.mode == MODE_DST_A) ||
                     (op_i.mode == MODE_CONST_A);
    mix_d.direct   = '0;
    for (int c = 0; c < NumCol; c++) begin
      s_ch = op_i.src[c*ChanW +: ChanW];
      d_ch = op_i.dst[c*ChanW +: ChanW];
      mix_d.prod_s[c] = {{ChanW{1'b0}}, s_ch} * {{ChanW{1'b0}}, op_i.alpha};
      mix_d.prod_d[c] = {{ChanW{1'b0}}, d_ch} * {{ChanW{1'b0}}, inv_alpha};
      case (op_i.mode)
        MODE_ADD: mix_d.direct[c*ChanW +: ChanW] = add_sat(s_ch, d_ch);
        MODE_SUB: mix_d.direct[c*ChanW +: ChanW] = sub_sat(s_ch, d_ch);
        default:  ;
      endcase
    end
    case (op_i.mode)
      MODE_COPY:    mix_d.direct = op_i.src;
      MODE_INV_SRC: mix_d.direct = ~op_i.src;
      MODE_INV_DST: mix_d.direct = ~op_i.dst;
      default:      ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      mix_q <= mix_d;
    end
  end

  assign valid_o = valid_q;
  assign mix_o   = mix_q;

endmodule

// File: hw/rtl/abp_out_stage.sv
module abp_out_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  abp_pkg::mix_t             mix_i,
  output logic                      valid_o,
  output logic [abp_pkg::PixW-1:0]  pixel_o
);
  import abp_pkg::*;

  logic            valid_q;
  logic [PixW-1:0] pixel_d, pixel_q;
  logic [ProdW:0]  sum;

  // Add the products and keep the high byte with the alpha byte cleared, or pass the direct result for non-blend modes
  always_comb begin
    pixel_d = '0;
    for (int c = 0; c < NumCol; c++) begin
      sum = {1'b0, mix_i.prod_s[c]} + {1'b0, mix_i.prod_d[c]};
      pixel_d[c*ChanW +: ChanW] = sum[ProdW-1:ChanW];
    end
    if (!mix_i.is_blend) begin
      pixel_d = mix_i.direct;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      pixel_q <= pixel_d;
    end
  end

  assign valid_o = valid_q;
  assign pixel_o = pixel_q;

endmodule

// File: hw/rtl/argb_pixel_blend_unit.sv
// Channel   Handshake             Payload
// request   start_i / busy_o      src_pixel_i, dst_pixel_i
// result    done_o (strobe)       out_pixel_o
// config    cfg_valid_i/ready_o   cfg_index_i, cfg_data_i
//
// A taken request passes the operand select, channel multiply, and sum and
// output register stages in order and appears on out_pixel_o with done_o.
// busy_o is never raised, so one request per cycle is taken. The result is
// shown for one cycle and cannot be stalled. rst_ni clears the pipeline valid
// bits and the registers to their defaults at once.
module argb_pixel_blend_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [abp_pkg::PixW-1:0]     src_pixel_i,
  input  logic [abp_pkg::PixW-1:0]     dst_pixel_i,
  output logic                         done_o,
  output logic [abp_pkg::PixW-1:0]     out_pixel_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [abp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [abp_pkg::PixW-1:0]     cfg_data_i
);
  import abp_pkg::*;

  cfg_t cfg;
  op_t  op;
  mix_t mix;
  logic req_acc;
  logic op_valid, mix_valid;

  assign busy_o  = 1'b0;
  assign req_acc = start_i && !busy_o;

  abp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  abp_operand_stage u_operand (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (req_acc),
    .src_i   (src_pixel_i),
    .dst_i   (dst_pixel_i),
    .cfg_i   (cfg),
    .valid_o (op_valid),
    .op_o    (op)
  );

  abp_mix_stage u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (op_valid),
    .op_i    (op),
    .valid_o (mix_valid),
    .mix_o   (mix)
  );

  abp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mix_valid),
    .mix_i   (mix),
    .valid_o (done_o),
    .pixel_o (out_pixel_o)
  );

  // Every accepted request comes out as a done_o strobe
  a_req_to_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |-> ##3 done_o)
    else $error("request did not complete after three cycles");

  // No result without a matching earlier request
  a_done_has_req : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(req_acc, 3))
    else $error("result strobe without a matching request");

  // A result needs a valid product stage the cycle before
  a_done_from_mix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(mix_valid))
    else $error("result strobe without product stage valid");

endmodule

// File: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import abp_pkg::*;

  typedef struct {
    logic [PixW-1:0] src;
    logic [PixW-1:0] dst;
  } pixel_pair_t;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned RandomItems = 1300;

  // Corner pixels swept through every mode
  localparam logic [PixW-1:0] CornerSrc [3] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000};
  localparam logic [PixW-1:0] CornerDst [3] = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF};

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                start_i     = 1'b0;
  logic                busy_o;
  logic [PixW-1:0]     src_pixel_i = '0;
  logic [PixW-1:0]     dst_pixel_i = '0;
  logic                done_o;
  logic [PixW-1:0]     out_pixel_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [PixW-1:0]     cfg_data_i  = '0;

  cfg_t            blend_cfg;
  pixel_pair_t     pending_pairs[$];
  logic [PixW-1:0] expected_pixels[$];
  logic            req_taken    = 1'b0;
  logic            cfg_taken    = 1'b0;
  bit              no_gaps      = 1'b0;
  int unsigned     gap_left     = 0;
  int unsigned     fail_count   = 0;
  int unsigned     stall_cycles = 0;

  argb_pixel_blend_unit uut (.*);

  initial forever #6 clk_i = ~clk_i;

  // Weight one channel: (s*a + d*(255-a)) >> 8
  function automatic logic [ChanW-1:0] weigh_chan(input logic [ChanW-1:0] s,
                                                  input logic [ChanW-1:0] d,
                                                  input logic [ChanW-1:0] a);
    int unsigned acc;
    acc = int'(s) * int'(a) + int'(d) * (255 - int'(a));
    return ChanW'(acc >> 8);
  endfunction

  // Predict the written-back pixel for one request under the given settings
  function automatic logic [PixW-1:0] blend_pixel(input cfg_t c,
                                                  input logic [PixW-1:0] src_px,
                                                  input logic [PixW-1:0] dst_px);
    logic [PixW-1:0]  s;
    logic [PixW-1:0]  px;
    logic [ChanW-1:0] a;
    logic [ChanW-1:0] sc;
    logic [ChanW-1:0] dc;
    s  = c.source_select ? c.fill_color : src_px;
    px = '0;
    case (c.mode)
      MODE_COPY:    px = s;
      MODE_INV_SRC: px = ~s;
      MODE_INV_DST: px = ~dst_px;
      default: begin
        a = (c.mode == MODE_SRC_A) ? s[31:24] :
            (c.mode == MODE_DST_A) ? dst_px[31:24] : c.const_alpha;
        // colour channels only, alpha byte stays clear
        for (int ch = 0; ch < NumCol; ch++) begin
          sc = s[ch*ChanW +: ChanW];
          dc = dst_px[ch*ChanW +: ChanW];
          case (c.mode)
            MODE_ADD: px[ch*ChanW +: ChanW] = (int'(sc) + int'(dc) > 255) ? ChanMax : sc + dc;
            MODE_SUB: px[ch*ChanW +: ChanW] = (dc > sc) ? dc - sc : '0;
            default:  px[ch*ChanW +: ChanW] = weigh_chan(sc, dc, a);
          endcase
        end
      end
    endcase
    return px;
  endfunction

  // Random pixel with each byte often at zero or full scale
  function automatic logic [PixW-1:0] rand_pixel();
    logic [PixW-1:0] px;
    for (int b = 0; b < PixW / ChanW; b++) begin
      case ($urandom_range(0, 7))
        0:       px[b*ChanW +: ChanW] = '0;
        1:       px[b*ChanW +: ChanW] = ChanMax;
        default: px[b*ChanW +: ChanW] = ChanW'($urandom);
      endcase
    end
    return px;
  endfunction

  // Write one register and hold until the channel takes it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [PixW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_taken);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= $urandom;
  endtask

  // Hold until every queued request has gone and every pixel has come back
  task automatic settle();
    do begin
      @(posedge clk_i);
      #1;
    end while (pending_pairs.size() != 0 || start_i || expected_pixels.size() != 0);
  endtask

  // Request driver: present queued pairs, with a randomly drawn idle gap between them, none when no_gaps is set
  always @(negedge clk_i) begin
    pixel_pair_t pair;
    if (!rst_ni) begin
      start_i  <= 1'b0;
      gap_left = 0;
    end else if (!start_i || req_taken) begin
      if (gap_left == 0 && pending_pairs.size() != 0) begin
        pair        = pending_pairs.pop_front();
        start_i     <= 1'b1;
        src_pixel_i <= pair.src;
        dst_pixel_i <= pair.dst;
        gap_left    = no_gaps ? 0 : $urandom_range(0, 6);
      end else begin
        if (gap_left != 0) gap_left--;
        start_i     <= 1'b0;
        src_pixel_i <= $urandom;
        dst_pixel_i <= $urandom;
      end
    end
  end

  // Monitor: check results, predict accepted requests, track register writes
  always @(posedge clk_i) begin
    logic [PixW-1:0] want;
    if (!rst_ni) begin
      blend_cfg = '{mode: MODE_COPY, const_alpha: ConstAlphaRst,
                    source_select: 1'b0, fill_color: '0};
      req_taken <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      if (done_o) begin
        if (expected_pixels.size() == 0) begin
          $error("out_pixel: expected nothing, actual %08h", out_pixel_o);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pixel_o !== want) begin
            $error("out_pixel: expected %08h, actual %08h", want, out_pixel_o);
            fail_count++;
          end
        end
      end
      if (start_i && !busy_o)
        expected_pixels.push_back(blend_pixel(blend_cfg, src_pixel_i, dst_pixel_i));
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_BLEND_MODE:    blend_cfg.mode          = blend_mode_e'(cfg_data_i[2:0]);
          REG_CONST_ALPHA:   blend_cfg.const_alpha   = cfg_data_i[ChanW-1:0];
          REG_SOURCE_SELECT: blend_cfg.source_select = cfg_data_i[0];
          REG_FILL_COLOR:    blend_cfg.fill_color    = cfg_data_i;
          default: ;
        endcase
      end
      req_taken    <= start_i && !busy_o;
      cfg_taken    <= cfg_valid_i && cfg_ready_o;
      stall_cycles <= (done_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) ?
                      0 : stall_cycles + 1;
    end
  end

  // Abort when nothing moves for too long
  initial begin
    while (stall_cycles < StallLimit) @(posedge clk_i);
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus: default-settings pairs, directed corners, then randomised phases
  initial begin
    int unsigned     total;
    int unsigned     ph;
    int unsigned     count;
    blend_mode_e     mode;
    logic [ChanW-1:0] alpha;
    logic            sel;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // default settings straight out of reset
    pending_pairs.push_back('{src: 32'h8012_34FE, dst: 32'h7F9A_BC01});
    pending_pairs.push_back('{src: 32'hFFFF_FFFF, dst: 32'h0000_0000});
    settle();

    // every mode over the corner pixels
    for (int m = 0; m < 8; m++) begin
      write_reg(REG_BLEND_MODE, {29'($urandom), 3'(m)});
      for (int k = 0; k < 3; k++)
        pending_pairs.push_back('{src: CornerSrc[k], dst: CornerDst[k]});
      settle();
    end

    // random phases, each under its own settings
    total = 0;
    ph    = 0;
    while (total < RandomItems) begin
      mode = (ph < 16) ? blend_mode_e'(ph[2:0]) : blend_mode_e'($urandom_range(0, 7));
      write_reg(REG_BLEND_MODE, {29'($urandom), mode});
      if (ph < 16 || $urandom_range(0, 1) == 0) begin
        alpha = (ph == 7) ? '0 : (ph == 15) ? ChanMax : ChanW'(rand_pixel());
        write_reg(REG_CONST_ALPHA, {24'($urandom), alpha});
      end
      sel = (ph % 4 == 3) || ($urandom_range(0, 4) == 0);
      write_reg(REG_SOURCE_SELECT, {31'($urandom), sel});
      if (sel || $urandom_range(0, 3) == 0)
        write_reg(REG_FILL_COLOR, rand_pixel());
      no_gaps = ($urandom_range(0, 2) == 0);
      count   = $urandom_range(20, 60);
      repeat (count) pending_pairs.push_back('{src: rand_pixel(), dst: rand_pixel()});
      total += count;
      ph++;
      settle();
    end

    // let the pipeline empty before the verdict
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
